>>> rtl/vrt_pkg.sv
// shared constants and controller/datapath command types for the voxel ray traversal block
// no dependencies
`default_nettype none
package vrt_pkg;
  localparam int WORLD_BITS_DEF = 6;
  localparam int CHUNK_BITS_DEF = 4;
  localparam int MAX_STEPS_DEF  = 1024;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W = 24;
  localparam int DIST_W  = 26;
  localparam int FIELD_W = 6;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic clr;        // clear one occupancy entry of the sweep
    logic load;       // capture a cast beat
    logic sqrt_start;
    logic ndiv_start; // start normalize division for axis
    logic tdiv_start; // start tdelta division
    logic gdiv_start; // start first boundary division
    logic [1:0] axis;
    logic visit;      // one traversal visit
    logic rd;         // issue occupancy read
  } vrt_cmd_t;

  typedef struct packed {
    logic clr_last;   // sweep at the last occupancy entry
    logic busy;       // divider or root busy
    logic len_zero;
    logic n_zero;     // current axis normalizes to zero
    logic beyond;     // min tmax exceeds max distance
    logic occ;        // registered occupancy bit
  } vrt_stat_t;
endpackage
`default_nettype wire

>>> rtl/vrt_datapath.sv
// datapath: occupancy memory, iterative root and divider, per-axis dda registers
// depends on vrt_pkg
`default_nettype none
module vrt_datapath #(
  parameter int WORLD_BITS = vrt_pkg::WORLD_BITS_DEF,
  parameter int CHUNK_BITS = vrt_pkg::CHUNK_BITS_DEF,
  parameter int MAX_STEPS  = vrt_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire logic [5:0] wx, wy, wz,
  input  wire logic wsolid,
  input  wire logic signed [23:0] ox, oy, oz, dx, dy, dz,
  input  wire logic [25:0] maxd_in,
  input  wire vrt_pkg::vrt_cmd_t cmd,
  output vrt_pkg::vrt_stat_t stat,
  output logic [5:0] hx, hy, hz,
  output logic [1:0] cx, cy, cz,
  output logic [25:0] tmin
);
  localparam int DEPTH = 1 << (3*WORLD_BITS);
  // voxel coordinate covers the origin range plus MAX_STEPS steps either way
  localparam int GW0 = (24 - FRAC_BITS) + $clog2(MAX_STEPS) + 2;
  localparam int GW = (GW0 > WORLD_BITS + 2) ? GW0 : WORLD_BITS + 2;
  localparam int SW = 48;
  localparam int DW = 2*FRAC_BITS + 24; // divider numerator width
  localparam logic [25:0] DMAX = '1;
  localparam logic [1:0] DK_NORM = 2'd0;
  localparam logic [1:0] DK_TDEL = 2'd1;
  localparam logic [1:0] DK_GAP  = 2'd2;

  logic mem [DEPTH];
  logic occ;
  logic signed [GW-1:0] vox [3];
  logic [1:0] stp [3]; // bit1 = moves, bit0 = negative
  logic [25:0] tmax [3], tdel [3];
  logic [23:0] mag [3];
  logic [FRAC_BITS-1:0] frac [3];
  logic [FRAC_BITS:0] nval [3];
  logic [25:0] maxd;

  // write port and registered read
  logic [3*WORLD_BITS-1:0] ridx;
  logic rin;
  always_comb begin
    ridx = {vox[2][WORLD_BITS-1:0], vox[1][WORLD_BITS-1:0], vox[0][WORLD_BITS-1:0]};
    rin = 1'b1;
    for (int a = 0; a < 3; a++)
      if (vox[a] < 0 || vox[a] >= GW'(1 << WORLD_BITS)) rin = 1'b0;
  end
  logic wfit;
  assign wfit = (WORLD_BITS >= 6) ||
                ((({wx, wy, wz} >> 0) & 18'h0) == 0 &&
                 (wx >> WORLD_BITS) == 0 && (wy >> WORLD_BITS) == 0 &&
                 (wz >> WORLD_BITS) == 0);
  logic [3*WORLD_BITS-1:0] widx;
  assign widx = {WORLD_BITS'(wz), WORLD_BITS'(wy), WORLD_BITS'(wx)};

  // clearing sweep address, advancing one entry per clear command from reset
  logic [3*WORLD_BITS-1:0] clr_idx;
  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clr) clr_idx <= clr_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) mem[clr_idx] <= 1'b0;
    else if (wr_en && wfit) mem[widx] <= wsolid;
    if (cmd.rd) occ <= rin ? mem[ridx] : 1'b0;
  end

  // root: one result bit a cycle
  logic [SW-1:0] sq_v, sq_r, sq_b;
  logic sq_busy;
  always_ff @(posedge clk) begin
    if (rst) sq_busy <= 1'b0;
    else if (cmd.sqrt_start) begin
      sq_v <= SW'(mag[0]*mag[0]) + SW'(mag[1]*mag[1]) + SW'(mag[2]*mag[2]);
      sq_r <= '0; sq_b <= SW'(1) << (SW-2); sq_busy <= 1'b1;
    end else if (sq_busy) begin
      if (sq_v >= sq_r + sq_b) begin
        sq_v <= sq_v - (sq_r + sq_b); sq_r <= (sq_r >> 1) + sq_b;
      end else sq_r <= sq_r >> 1;
      sq_b <= sq_b >> 2;
      if (sq_b == SW'(1)) sq_busy <= 1'b0;
    end
  end
  logic [24:0] len;
  assign len = sq_r[24:0];

  // shared restoring divider, one quotient bit a cycle
  logic [DW-1:0] dv_q, dv_rem;
  logic [DW-1:0] dv_den;
  logic [$clog2(DW+1)-1:0] dv_cnt;
  logic dv_busy;
  logic [1:0] dv_kind; // division kind: normalize, tdelta or gap
  logic [1:0] dv_ax;
  logic [DW:0] dv_trial;
  assign dv_trial = {dv_rem, dv_q[DW-1]};
  logic [FRAC_BITS:0] gap;
  always_comb begin
    if (stp[cmd.axis][0]) gap = {1'b0, frac[cmd.axis]};
    else gap = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac[cmd.axis]};
  end
  always_ff @(posedge clk) begin
    if (rst) dv_busy <= 1'b0;
    else if (cmd.ndiv_start || cmd.tdiv_start || cmd.gdiv_start) begin
      dv_busy <= 1'b1; dv_cnt <= '0; dv_rem <= '0; dv_ax <= cmd.axis;
      if (cmd.ndiv_start) begin
        dv_kind <= DK_NORM; dv_q <= DW'(mag[cmd.axis]) << FRAC_BITS; dv_den <= DW'(len);
      end else if (cmd.tdiv_start) begin
        dv_kind <= DK_TDEL; dv_q <= DW'(1) << (2*FRAC_BITS);
        dv_den <= DW'(nval[cmd.axis]);
      end else begin
        dv_kind <= DK_GAP; dv_q <= DW'(gap) << FRAC_BITS; dv_den <= DW'(nval[cmd.axis]);
      end
    end else if (dv_busy) begin
      if (dv_trial >= {1'b0, dv_den}) begin
        dv_rem <= DW'(dv_trial - {1'b0, dv_den}); dv_q <= {dv_q[DW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_trial[DW-1:0]; dv_q <= {dv_q[DW-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt + 1'b1;
      if (dv_cnt == ($clog2(DW+1))'(DW-1)) dv_busy <= 1'b0;
    end
  end
  logic dv_done;
  always_ff @(posedge clk) begin
    if (rst) dv_done <= 1'b0;
    else dv_done <= dv_busy && dv_cnt == ($clog2(DW+1))'(DW-1);
  end
  logic [25:0] qsat;
  assign qsat = (dv_q > DW'(DMAX)) ? DMAX : dv_q[25:0];

  // axis choice
  logic [1:0] ax;
  always_comb begin
    tmin = tmax[0];
    if (tmax[1] < tmin) tmin = tmax[1];
    if (tmax[2] < tmin) tmin = tmax[2];
    if (tmax[0] < tmax[1]) ax = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else ax = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
  end
  logic [26:0] tsum;
  assign tsum = {1'b0, tmax[ax]} + {1'b0, tdel[ax]};

  // per-axis registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag[0] <= dx[23] ? 24'(-dx) : dx; mag[1] <= dy[23] ? 24'(-dy) : dy;
      mag[2] <= dz[23] ? 24'(-dz) : dz;
      frac[0] <= ox[FRAC_BITS-1:0]; frac[1] <= oy[FRAC_BITS-1:0];
      frac[2] <= oz[FRAC_BITS-1:0];
      vox[0] <= GW'(ox >>> FRAC_BITS); vox[1] <= GW'(oy >>> FRAC_BITS);
      vox[2] <= GW'(oz >>> FRAC_BITS);
      stp[0] <= {1'b0, dx[23]}; stp[1] <= {1'b0, dy[23]}; stp[2] <= {1'b0, dz[23]};
      for (int a = 0; a < 3; a++) begin
        tmax[a] <= DMAX; tdel[a] <= DMAX;
      end
      maxd <= maxd_in;
    end else if (dv_done) begin
      unique case (dv_kind)
        DK_NORM: nval[dv_ax] <= dv_q[FRAC_BITS:0];
        DK_TDEL: begin tdel[dv_ax] <= qsat; stp[dv_ax][1] <= 1'b1; end
        default: tmax[dv_ax] <= qsat;
      endcase
    end else if (cmd.visit) begin
      if (stp[ax][1]) vox[ax] <= stp[ax][0] ? vox[ax] - 1'b1 : vox[ax] + 1'b1;
      tmax[ax] <= tsum[26] || tsum[25:0] == DMAX ? DMAX : tsum[25:0];
    end
  end

  assign hx = vrt_pkg::FIELD_W'(vox[0]);
  assign hy = vrt_pkg::FIELD_W'(vox[1]);
  assign hz = vrt_pkg::FIELD_W'(vox[2]);
  assign cx = 2'(vox[0] >>> CHUNK_BITS);
  assign cy = 2'(vox[1] >>> CHUNK_BITS);
  assign cz = 2'(vox[2] >>> CHUNK_BITS);

  always_comb begin
    stat.clr_last = (clr_idx == '1);
    stat.busy = sq_busy || dv_busy || dv_done;
    stat.len_zero = (len == '0);
    stat.n_zero = (nval[cmd.axis] == '0);
    stat.beyond = tmin > maxd;
    stat.occ = occ;
  end
endmodule
`default_nettype wire

>>> rtl/vrt_ctrl.sv
// controller: sequences setup, traversal visits and result hand-off
// depends on vrt_pkg
`default_nettype none
module vrt_ctrl #(
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_cmd,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  output logic out_hit,
  output logic out_sel_max,
  output logic out_load,
  input  wire vrt_pkg::vrt_stat_t stat,
  output vrt_pkg::vrt_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROOT, S_RWAIT, S_NORM, S_NWAIT, S_TDIV, S_TWAIT, S_GDIV,
    S_GWAIT, S_READ, S_RWT, S_CHECK, S_DONE
  } state_t;
  state_t state;
  logic [1:0] axis;
  logic [$clog2(MAX_STEPS+1)-1:0] steps;
  logic go;

  assign in_stall = (state != S_IDLE);
  assign go = in_valid && !in_stall && in_cmd == vrt_pkg::CMD_CAST;
  // result register takes the new beat when empty or as the old one is taken
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.clr = (state == S_CLEAR);
    cmd.load = go;
    cmd.sqrt_start = (state == S_ROOT);
    cmd.ndiv_start = (state == S_NORM);
    cmd.tdiv_start = (state == S_TDIV) && !stat.n_zero;
    cmd.gdiv_start = (state == S_GDIV) && !stat.n_zero;
    cmd.rd = (state == S_READ);
    cmd.visit = (state == S_CHECK) && !stat.beyond && !stat.occ &&
                steps != ($clog2(MAX_STEPS+1))'(MAX_STEPS);
  end

  // state and registered result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; out_valid <= 1'b0; axis <= '0; steps <= '0;
      out_hit <= 1'b0; out_sel_max <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (stat.clr_last) state <= S_IDLE;
        S_IDLE: if (go) state <= S_ROOT;
        S_ROOT: state <= S_RWAIT;
        S_RWAIT: if (!stat.busy) begin
          if (stat.len_zero) begin
            out_hit <= 1'b0; out_sel_max <= 1'b1; state <= S_DONE;
          end else begin
            axis <= 2'd0; state <= S_NORM;
          end
        end
        S_NORM: state <= S_NWAIT;
        S_NWAIT: if (!stat.busy) state <= S_TDIV;
        S_TDIV: state <= stat.n_zero ? S_GWAIT : S_TWAIT;
        S_TWAIT: if (!stat.busy) state <= S_GDIV;
        S_GDIV: state <= S_GWAIT;
        S_GWAIT: if (!stat.busy) begin
          if (axis == 2'd2) begin
            steps <= '0; state <= S_READ;
          end else begin
            axis <= axis + 2'd1; state <= S_NORM;
          end
        end
        S_READ: state <= S_RWT;
        S_RWT: state <= S_CHECK;
        S_CHECK: begin
          if (steps == ($clog2(MAX_STEPS+1))'(MAX_STEPS) || stat.beyond) begin
            out_hit <= 1'b0; out_sel_max <= 1'b1; state <= S_DONE;
          end else if (stat.occ) begin
            out_hit <= 1'b1; out_sel_max <= 1'b0; state <= S_DONE;
          end else begin
            steps <= steps + 1'b1; state <= S_READ;
          end
        end
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/voxel_ray_traversal.sv
// top level of the voxel ray traversal block
// depends on vrt_pkg, vrt_ctrl, vrt_datapath
`default_nettype none
// After reset the block clears its occupancy grid, one voxel a cycle, all
// 2^(3*WORLD_BITS) voxels (262144 at the default size), with in_stall high.
// A write beat (cmd 0) then updates one voxel and gives no result.
// A cast beat (cmd 1) gives one result beat. Setup runs the bit-serial root
// and then serial divisions through one shared divider (none for a zero direction,
// else five to nine: one normalize per axis, and for each axis that moves
// the per-voxel and the first boundary distance); each visited voxel then
// goes through the occupancy read, the read wait and the step compare,
// up to MAX_STEPS visits. The result sits in an output register, so later beats
// are taken while it waits; a finished cast holds until the previous result is
// taken. The grid is held in one bit memory with one write and one read port.
module voxel_ray_traversal #(
  parameter int WORLD_BITS = vrt_pkg::WORLD_BITS_DEF,
  parameter int CHUNK_BITS = vrt_pkg::CHUNK_BITS_DEF,
  parameter int MAX_STEPS  = vrt_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic cmd,
  input  wire logic [5:0] voxel_x, voxel_y, voxel_z,
  input  wire logic solid,
  input  wire logic signed [23:0] origin_x, origin_y, origin_z,
  input  wire logic signed [23:0] direction_x, direction_y, direction_z,
  input  wire logic [25:0] max_distance,
  output logic out_valid,
  input  wire logic out_stall,
  output logic hit,
  output logic [5:0] hit_x, hit_y, hit_z,
  output logic [1:0] chunk_x, chunk_y, chunk_z,
  output logic [25:0] distance
);
  vrt_pkg::vrt_cmd_t ctl;
  vrt_pkg::vrt_stat_t st;
  logic o_hit, o_max, o_load;
  logic [5:0] hx, hy, hz;
  logic [1:0] cx, cy, cz;
  logic [25:0] tmin, maxd_r;
  logic wr_en;

  assign wr_en = in_valid && !in_stall && cmd == vrt_pkg::CMD_WRITE;

  vrt_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(cmd), .in_stall, .out_valid, .out_stall,
    .out_hit(o_hit), .out_sel_max(o_max), .out_load(o_load), .stat(st), .cmd(ctl)
  );

  vrt_datapath #(.WORLD_BITS(WORLD_BITS), .CHUNK_BITS(CHUNK_BITS),
                 .MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .wr_en, .wx(voxel_x), .wy(voxel_y), .wz(voxel_z), .wsolid(solid),
    .ox(origin_x), .oy(origin_y), .oz(origin_z),
    .dx(direction_x), .dy(direction_y), .dz(direction_z),
    .maxd_in(max_distance), .cmd(ctl), .stat(st),
    .hx, .hy, .hz, .cx, .cy, .cz, .tmin
  );

  always_ff @(posedge clk) begin
    if (ctl.load) maxd_r <= max_distance;
  end

  // result register, held while the beat waits
  always_ff @(posedge clk) begin
    if (o_load) begin
      hit      <= o_hit;
      hit_x    <= o_hit ? hx : '0;
      hit_y    <= o_hit ? hy : '0;
      hit_z    <= o_hit ? hz : '0;
      chunk_x  <= o_hit ? cx : '0;
      chunk_y  <= o_hit ? cy : '0;
      chunk_z  <= o_hit ? cz : '0;
      distance <= o_max ? maxd_r : tmin;
    end
  end
endmodule
`default_nettype wire
